### hw/rtl/bbr_pkg.sv
package bbr_pkg;

  // Widths of the configuration registers and of the write port.
  localparam int FW_BITS       = 12;
  localparam int FH_BITS       = 13;
  localparam int CFG_ADDR_BITS = 1;
  localparam int CFG_DATA_BITS = 13;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_BITS-1:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_IDX_HEIGHT = 1'b1;

  // Register values after reset.
  localparam logic [FW_BITS-1:0] FW_RESET = 12'd640;
  localparam logic [FH_BITS-1:0] FH_RESET = 13'd480;

  // Beat kind carried on in_tuser.
  localparam logic OP_DRAIN = 1'b1;

  // Default sizing of the core.
  localparam int MAX_WIDTH_DEF    = 2048;
  localparam int CHANNEL_BITS_DEF = 8;

  // Depths of the command queue and of the result queue.
  localparam int CMDQ_DEPTH = 4;
  localparam int RESQ_DEPTH = 8;

  // Classification of one accepted beat, made by the front end.
  typedef struct packed {
    logic emit;      // beat releases one result
    logic interior;  // that result is a blurred pixel, not a border pass-through
    logic last;      // that result closes the frame
  } cmd_flags_t;

endpackage

### hw/rtl/bbr_fifo.sv
module bbr_fifo #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic                       not_empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PTRW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0]  count_r, count_nxt;

  function automatic logic [PTRW-1:0] ptr_inc(input logic [PTRW-1:0] p);
    ptr_inc = (p == PTRW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) store_r[wr_ptr_r] <= push_data;
  end

  assign pop_data  = store_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign full      = (count_r == CNTW'(DEPTH));
  assign count     = count_r;

endmodule

### hw/rtl/bbr_front.sv
module bbr_front #(
  parameter int MAX_WIDTH    = bbr_pkg::MAX_WIDTH_DEF,
  parameter int CHANNEL_BITS = bbr_pkg::CHANNEL_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [bbr_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [bbr_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  input  logic                               accept,
  input  logic                               operation,
  input  logic [3*CHANNEL_BITS-1:0]          pixel,
  output logic [$clog2(MAX_WIDTH)-1:0]       cmd_col,
  output logic [3*CHANNEL_BITS-1:0]          cmd_px,
  output bbr_pkg::cmd_flags_t                cmd_flags
);

  import bbr_pkg::*;

  localparam int ADDRW = $clog2(MAX_WIDTH);
  localparam int WCW   = $clog2(MAX_WIDTH + 1);
  localparam int CW    = WCW + 1;
  localparam int FCW   = ((FW_BITS > WCW) ? FW_BITS : WCW) + 1;
  localparam int IPW   = $clog2(MAX_WIDTH + 2);
  localparam int RW    = FH_BITS + 1;

  logic [FW_BITS-1:0] fw_r;
  logic [FH_BITS-1:0] fh_r;
  logic [ADDRW-1:0]   in_col_r;
  logic [IPW-1:0]     ipos_r;
  logic [ADDRW-1:0]   ocol_r;
  logic [FH_BITS-1:0] orow_r;

  logic [WCW-1:0]     w_eff;
  logic [FH_BITS-1:0] h_eff;
  logic [ADDRW-1:0]   col, col_nxt;
  logic [CW-1:0]      col_p1, c_p1;
  logic [RW-1:0]      r_p1;
  logic               col_wrap, c_wrap, r_last, emit, last;

  // Effective frame size: zero acts as one, widths beyond the line store saturate.
  always_comb begin
    if (fw_r == '0) begin
      w_eff = WCW'(1);
    end else if (FCW'(fw_r) > FCW'(MAX_WIDTH)) begin
      w_eff = WCW'(MAX_WIDTH);
    end else begin
      w_eff = WCW'(fw_r);
    end
    h_eff = (fh_r == '0) ? FH_BITS'(1) : fh_r;
  end

  always_comb begin
    col      = (CW'(in_col_r) >= CW'(w_eff)) ? '0 : in_col_r;
    col_p1   = CW'(col) + 1'b1;
    col_wrap = (col_p1 >= CW'(w_eff));
    col_nxt  = col_wrap ? '0 : col_p1[ADDRW-1:0];

    emit   = (ipos_r > IPW'(w_eff));
    c_p1   = CW'(ocol_r) + 1'b1;
    c_wrap = (c_p1 >= CW'(w_eff));
    r_p1   = RW'(orow_r) + 1'b1;
    r_last = (r_p1 >= RW'(h_eff));
    last   = r_last && c_wrap;
  end

  assign cmd_col            = col;
  assign cmd_px             = (operation == OP_DRAIN) ? '0 : pixel;
  assign cmd_flags.emit     = emit;
  assign cmd_flags.last     = emit && last;
  assign cmd_flags.interior = emit && (orow_r != '0) && (ocol_r != '0) && !r_last && !c_wrap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r     <= FW_RESET;
      fh_r     <= FH_RESET;
      in_col_r <= '0;
      ipos_r   <= '0;
      ocol_r   <= '0;
      orow_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_IDX_WIDTH:  fw_r <= cfg_wdata[FW_BITS-1:0];
          CFG_IDX_HEIGHT: fh_r <= cfg_wdata[FH_BITS-1:0];
        endcase
      end
      if (accept) begin
        if (!emit) begin
          ipos_r   <= ipos_r + 1'b1;
          in_col_r <= col_nxt;
        end else if (last) begin
          // Frame done: every counter restarts for the next frame.
          ipos_r   <= '0;
          in_col_r <= '0;
          ocol_r   <= '0;
          orow_r   <= '0;
        end else begin
          in_col_r <= col_nxt;
          if (c_wrap) begin
            ocol_r <= '0;
            orow_r <= r_p1[FH_BITS-1:0];
          end else begin
            ocol_r <= c_p1[ADDRW-1:0];
          end
        end
      end
    end
  end

endmodule

### hw/rtl/bbr_back.sv
module bbr_back #(
  parameter int MAX_WIDTH    = bbr_pkg::MAX_WIDTH_DEF,
  parameter int CHANNEL_BITS = bbr_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cmd_valid,
  input  logic [$clog2(MAX_WIDTH)-1:0]            cmd_col,
  input  logic [3*CHANNEL_BITS-1:0]               cmd_px,
  input  bbr_pkg::cmd_flags_t                     cmd_flags,
  output logic                                    cmd_pop,
  input  logic [$clog2(bbr_pkg::RESQ_DEPTH+1)-1:0] res_count,
  output logic                                    res_push,
  output logic [3*CHANNEL_BITS:0]                 res_data
);

  import bbr_pkg::*;

  localparam int ADDRW = $clog2(MAX_WIDTH);
  localparam int CB    = CHANNEL_BITS;
  localparam int PIXW  = 3 * CB;
  localparam int SUMW  = CB + 4;
  // Divide by nine as a multiply by a rounded-up reciprocal; exact for any sum below 2^SUMW.
  localparam int DIV_K = SUMW + 4;
  localparam int MW    = DIV_K - 2;
  localparam logic [63:0] DIV_M64 = ((64'd1 << DIV_K) + 64'd8) / 64'd9;
  localparam logic [MW-1:0] DIV_M = DIV_M64[MW-1:0];
  localparam int PRODW = SUMW + MW;
  localparam int QW    = $clog2(RESQ_DEPTH + 1);

  // Each entry holds the older row in the upper half and the newer row in the lower half.
  logic [2*PIXW-1:0] line_mem [MAX_WIDTH];

  logic              b1_v_r;
  logic [ADDRW-1:0]  b1_col_r;
  logic [PIXW-1:0]   b1_px_r;
  cmd_flags_t        b1_flags_r;
  logic [2*PIXW-1:0] rd_r, byp_data_r;
  logic              byp_r;

  logic [PIXW-1:0]   win_r [3][3];
  logic              b2_v_r;
  cmd_flags_t        b2_flags_r;

  logic              b3_v_r;
  cmd_flags_t        b3_flags_r;
  logic [SUMW-1:0]   b3_sum_r [3];
  logic [PIXW-1:0]   b3_ctr_r;

  logic [2*PIXW-1:0] eff;
  logic [PIXW-1:0]   eff_newer, eff_older;
  logic [QW:0]       used;
  logic [SUMW-1:0]   row_sum [3][3];
  logic [SUMW-1:0]   win_sum [3];
  logic [PRODW-1:0]  prod [3];
  logic [PIXW-1:0]   res_px;

  // Results already owed by the pipeline reserve their queue slots before a pop.
  always_comb begin
    used    = (QW+1)'(res_count) + (QW+1)'(b1_v_r) + (QW+1)'(b2_v_r) + (QW+1)'(b3_v_r);
    cmd_pop = cmd_valid && (used < (QW+1)'(RESQ_DEPTH));
  end

  // A write still landing in the same cycle as the read is forwarded.
  assign eff       = byp_r ? byp_data_r : rd_r;
  assign eff_newer = eff[PIXW-1:0];
  assign eff_older = eff[2*PIXW-1:PIXW];

  always_ff @(posedge clk) begin
    if (cmd_pop) rd_r <= line_mem[cmd_col];
    if (b1_v_r)  line_mem[b1_col_r] <= {eff_newer, b1_px_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      b3_v_r <= 1'b0;
    end else begin
      b1_v_r <= cmd_pop;
      b2_v_r <= b1_v_r && b1_flags_r.emit;
      b3_v_r <= b2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      b1_col_r   <= cmd_col;
      b1_px_r    <= cmd_px;
      b1_flags_r <= cmd_flags;
      byp_r      <= b1_v_r && (b1_col_r == cmd_col);
      byp_data_r <= {eff_newer, b1_px_r};
    end
    if (b1_v_r) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= eff_older;
      win_r[1][2] <= eff_newer;
      win_r[2][2] <= b1_px_r;
      b2_flags_r  <= b1_flags_r;
    end
    if (b2_v_r) begin
      b3_sum_r   <= win_sum;
      b3_ctr_r   <= win_r[1][1];
      b3_flags_r <= b2_flags_r;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        row_sum[k][i] = SUMW'(win_r[i][0][k*CB +: CB]) + SUMW'(win_r[i][1][k*CB +: CB])
                      + SUMW'(win_r[i][2][k*CB +: CB]);
      end
      win_sum[k] = row_sum[k][0] + row_sum[k][1] + row_sum[k][2];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = PRODW'(b3_sum_r[k]) * PRODW'(DIV_M);
      res_px[k*CB +: CB] = b3_flags_r.interior ? prod[k][DIV_K +: CB]
                                               : b3_ctr_r[k*CB +: CB];
    end
  end

  assign res_push = b3_v_r;
  assign res_data = {b3_flags_r.last, res_px};

endmodule

### hw/rtl/box_blur_3x3_rgb_core.sv
// 3x3 box blur over an RGB pixel stream in raster order.
// Pixels arrive as beats on the in_ stream (in_tuser high marks a drain beat
// with no data) and leave as beats on the out_ stream. Each interior pixel
// becomes, per channel, the floor of its 3x3 neighborhood sum divided by nine;
// pixels on the frame border pass through. The result for a pixel appears
// once frame_width+1 further beats have been taken, so the source follows the
// last pixel of a frame with frame_width+1 drain beats; out_tlast marks the
// last pixel of the frame. frame_width and frame_height must be written through
// the cfg_ port only while the core is idle; the core does not enforce this.
// Throughput is one beat per clock on both sides while the receiver does not
// stall. A beat that releases a result passes through the command queue,
// then line store read, window update, and neighborhood sum, with the divide
// by nine folded into the result queue write, before it shows on out_tvalid.
// When the receiver stalls, the result queue fills and then the command
// queue; in_tready drops only once the command queue is full.
// Reset empties both queues and restores 640x480; the line stores keep
// whatever they held and are refilled by the first two rows of each frame.
module box_blur_3x3_rgb_core #(
  parameter int MAX_WIDTH    = bbr_pkg::MAX_WIDTH_DEF,
  parameter int CHANNEL_BITS = bbr_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_we,
  input  logic [bbr_pkg::CFG_ADDR_BITS-1:0]        cfg_addr,
  input  logic [bbr_pkg::CFG_DATA_BITS-1:0]        cfg_wdata,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0]      in_tdata,   // red, green, blue
  input  logic                                     in_tuser,   // operation
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  output logic [((3*CHANNEL_BITS+7)/8)*8-1:0]      out_tdata,  // out_red, out_green, out_blue
  output logic                                     out_tlast   // frame_end
);

  import bbr_pkg::*;

  localparam int ADDRW = $clog2(MAX_WIDTH);
  localparam int PIXW  = 3 * CHANNEL_BITS;
  localparam int DATAW = ((PIXW + 7) / 8) * 8;
  localparam int FLAGW = $bits(cmd_flags_t);
  localparam int CMDW  = FLAGW + ADDRW + PIXW;
  localparam int RESW  = PIXW + 1;

  logic              accept;
  logic [ADDRW-1:0]  cmd_col, q_col;
  logic [PIXW-1:0]   cmd_px, q_px;
  cmd_flags_t        cmd_flags, q_flags;
  logic [CMDW-1:0]   q_data;
  logic              cmd_valid, cmd_full, cmd_pop;
  logic [$clog2(CMDQ_DEPTH+1)-1:0] cmd_count;

  logic              res_push, res_full;
  logic [RESW-1:0]   res_in, res_out;
  logic [$clog2(RESQ_DEPTH+1)-1:0] res_count;

  assign in_tready = !cmd_full;
  assign accept    = in_tvalid && in_tready;

  // Front end: keeps the frame counters and tags every beat.
  bbr_front #(
    .MAX_WIDTH    (MAX_WIDTH),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .operation (in_tuser),
    .pixel     (in_tdata[PIXW-1:0]),
    .cmd_col   (cmd_col),
    .cmd_px    (cmd_px),
    .cmd_flags (cmd_flags)
  );

  // Command queue: lets the front keep taking beats while the back end waits.
  bbr_fifo #(
    .DEPTH (CMDQ_DEPTH),
    .WIDTH (CMDW)
  ) u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data ({cmd_flags, cmd_col, cmd_px}),
    .pop       (cmd_pop),
    .pop_data  (q_data),
    .not_empty (cmd_valid),
    .full      (cmd_full),
    .count     (cmd_count)
  );

  assign {q_flags, q_col, q_px} = q_data;

  // Back end: line store, sliding window, sum and divide.
  bbr_back #(
    .MAX_WIDTH    (MAX_WIDTH),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_col   (q_col),
    .cmd_px    (q_px),
    .cmd_flags (q_flags),
    .cmd_pop   (cmd_pop),
    .res_count (res_count),
    .res_push  (res_push),
    .res_data  (res_in)
  );

  // Result queue: holds finished pixels while the receiver stalls.
  bbr_fifo #(
    .DEPTH (RESQ_DEPTH),
    .WIDTH (RESW)
  ) u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_in),
    .pop       (out_tvalid && out_tready),
    .pop_data  (res_out),
    .not_empty (out_tvalid),
    .full      (res_full),
    .count     (res_count)
  );

  assign out_tdata = DATAW'(res_out[PIXW-1:0]);
  assign out_tlast = res_out[PIXW];

  // The back end reserves a result slot before it pops, so a push never meets a full queue.
  assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !res_full)
    else $error("result queue overflow");

  // The end of a frame is only ever tagged on a beat that releases a border result.
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && cmd_flags.last) |-> (cmd_flags.emit && !cmd_flags.interior))
    else $error("frame end tagged on a beat without a border result");

  // The command queue never reports more entries than it has.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd_count <= ($clog2(CMDQ_DEPTH+1))'(CMDQ_DEPTH))
    else $error("command queue count out of range");

  // Nothing is offered on the output right after reset.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

### sim/box_blur_3x3_rgb_core_test.sv
module box_blur_3x3_rgb_core_test;
  import bbr_pkg::*;

  // Stream geometry. Three channels packed red, green, blue from the lowest bit up.
  localparam int CH_BITS    = CHANNEL_BITS_DEF;
  localparam int TDATA_BITS = ((3 * CH_BITS + 7) / 8) * 8;

  // A plain pixel beat; the drain kind comes from the package.
  localparam logic OP_PIXEL = 1'b0;

  // Pixel patterns for a frame.
  localparam int PAT_RANDOM  = 0;
  localparam int PAT_FULL    = 1;
  localparam int PAT_CHECKER = 2;

  // A full run, even when every beat releases a result under the slowest
  // receiver, stays far below this limit, which leaves a wide margin.
  localparam int CYCLE_LIMIT   = 100000;
  localparam int HOLD_CYCLES   = 400;
  // Covers the path from the accepting edge to out_tvalid, with some margin.
  localparam int SETTLE_CYCLES = 8;
  // Random beats per idling regime; with the directed frames about 1700 in all.
  localparam int RANDOM_BEATS  = 250;

  typedef struct packed {
    logic [TDATA_BITS-1:0] rgb;
    logic                  frame_end;
  } blur_out_t;

  // Mirrors the core: line stores, the 3x3 window and the frame counters.
  // Every accepted beat advances the window; once a row plus one pixel has
  // gone in, each beat yields one output pixel, which is queued here and
  // compared against the next beat that leaves the core.
  class blur_checker;
    logic [FW_BITS-1:0]    width_reg;
    logic [FH_BITS-1:0]    height_reg;
    logic [TDATA_BITS-1:0] older_row [MAX_WIDTH_DEF];
    logic [TDATA_BITS-1:0] newer_row [MAX_WIDTH_DEF];
    logic [TDATA_BITS-1:0] win [3][3];
    int                    beats_in;
    int                    in_col;
    int                    out_col;
    int                    out_row;
    blur_out_t             pending_pixels [$];
    int                    errors;

    function new();
      width_reg  = FW_RESET;
      height_reg = FH_RESET;
      // The line stores are never read back into a result before being written.
      foreach (older_row[i]) older_row[i] = '0;
      foreach (newer_row[i]) newer_row[i] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      beats_in = 0;
      in_col   = 0;
      out_col  = 0;
      out_row  = 0;
      errors   = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
      if (idx == CFG_IDX_WIDTH) width_reg = val[FW_BITS-1:0];
      else height_reg = val[FH_BITS-1:0];
    endfunction

    // Zero acts as one and widths beyond the line store saturate.
    function int line_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
      return int'(width_reg);
    endfunction

    function int frame_rows();
      return (height_reg == 0) ? 1 : int'(height_reg);
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction

    function void take_pixel(logic op, logic [TDATA_BITS-1:0] data);
      int w, h, col, r, c, k, i, j, s;
      logic [TDATA_BITS-1:0] px;
      blur_out_t res;
      w = line_width();
      h = frame_rows();
      // A drain beat travels as a black pixel.
      px = (op == OP_DRAIN) ? '0 : data;
      col = (in_col >= w) ? 0 : in_col;
      for (i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = older_row[col];
      win[1][2] = newer_row[col];
      win[2][2] = px;
      older_row[col] = newer_row[col];
      newer_row[col] = px;
      in_col = (col + 1 >= w) ? 0 : col + 1;
      if (beats_in < w + 1) begin
        beats_in++;
        return;
      end
      r = out_row;
      c = out_col;
      res.rgb = '0;
      if (r != 0 && c != 0 && r + 1 < h && c + 1 < w) begin
        for (k = 0; k < 3; k++) begin
          s = 0;
          for (i = 0; i < 3; i++)
            for (j = 0; j < 3; j++)
              s += int'(win[i][j][CH_BITS*k +: CH_BITS]);
          res.rgb[CH_BITS*k +: CH_BITS] = CH_BITS'(s / 9);
        end
      end else begin
        res.rgb = win[1][1];
      end
      res.frame_end = (r + 1 >= h && c + 1 >= w);
      pending_pixels.push_back(res);
      if (res.frame_end) begin
        beats_in = 0;
        in_col   = 0;
        out_col  = 0;
        out_row  = 0;
      end else if (c + 1 >= w) begin
        out_col = 0;
        out_row = r + 1;
      end else begin
        out_col = c + 1;
      end
    endfunction

    function void match_result(logic [TDATA_BITS-1:0] rgb, logic frame_end);
      blur_out_t want;
      int k;
      if (pending_pixels.size() == 0) begin
        $display("%0t: result with nothing expected: rgb %h frame_end %b",
                 $time, rgb, frame_end);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      for (k = 0; k < 3; k++) begin
        if (rgb[CH_BITS*k +: CH_BITS] !== want.rgb[CH_BITS*k +: CH_BITS]) begin
          $display("%0t: %s expected %0d, got %0d", $time,
                   (k == 0) ? "red" : (k == 1) ? "green" : "blue",
                   want.rgb[CH_BITS*k +: CH_BITS], rgb[CH_BITS*k +: CH_BITS]);
          errors++;
        end
      end
      if (frame_end !== want.frame_end) begin
        $display("%0t: frame_end expected %b, got %b", $time, want.frame_end, frame_end);
        errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [TDATA_BITS-1:0]    in_tdata = '0;   // red, green, blue
  logic                     in_tuser = 1'b0; // operation
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [TDATA_BITS-1:0]    out_tdata;       // out_red, out_green, out_blue
  logic                     out_tlast;       // frame_end

  blur_checker chk;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          beats_sent = 0;
  int          cycles = 0;
  int          hold_left = 0;
  logic        hold_kick = 1'b0;

  box_blur_3x3_rgb_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Watchdog. A hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, chk.pending());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // The long receiver hold-off runs on its own count so that the sender keeps
  // offering beats while the result and command queues fill up behind it.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_kick) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // The receiver stalls at random at the current regime's rate.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct) && (hold_left == 0);
    end
  end

  // Both sides are sampled at the edge. Every drive is nonblocking, so the
  // values seen here are the ones the core saw when it took the beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) chk.take_pixel(in_tuser, in_tdata);
      if (out_tvalid && out_tready) chk.match_result(out_tdata, out_tlast);
    end
  end

  // Offers one beat, after a random gap, and returns at the edge that takes it.
  task automatic send_beat(input logic op, input logic [TDATA_BITS-1:0] pix);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= pix;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
  endtask

  // The width and then the height register go in on back-to-back edges; the predictor follows.
  task automatic write_frame_size(input int fw, input int fh);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_IDX_WIDTH;
    cfg_wdata <= CFG_DATA_BITS'(fw);
    chk.write_reg(CFG_IDX_WIDTH, CFG_DATA_BITS'(fw));
    @(posedge clk);
    cfg_addr  <= CFG_IDX_HEIGHT;
    cfg_wdata <= CFG_DATA_BITS'(fh);
    chk.write_reg(CFG_IDX_HEIGHT, CFG_DATA_BITS'(fh));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One whole frame at the current size, followed by width+1 drain beats.
  // The first lead_drains pixels go out as drain beats, which is what surplus
  // drains from the previous frame look like; drain_pct scatters further drain
  // beats through the frame as black pixels.
  task automatic send_frame(input int pattern, input int lead_drains, input int drain_pct);
    int fw, fh, n, k, sel;
    logic op;
    logic [TDATA_BITS-1:0] v;
    fw = chk.line_width();
    fh = chk.frame_rows();
    for (n = 0; n < fw * fh; n++) begin
      op = (n < lead_drains || $urandom_range(99) < drain_pct) ? OP_DRAIN : OP_PIXEL;
      v = '0;
      case (pattern)
        PAT_FULL: begin
          v[3*CH_BITS-1:0] = '1;
        end
        PAT_CHECKER: begin
          if (((n % fw) + (n / fw)) % 2 == 1) v[3*CH_BITS-1:0] = '1;
        end
        default: begin
          // Lean toward the channel extremes so that floor and carry corners come up.
          for (k = 0; k < 3; k++) begin
            sel = $urandom_range(7);
            v[CH_BITS*k +: CH_BITS] = (sel == 0) ? '0 : (sel == 1) ? '1 : CH_BITS'($urandom);
          end
        end
      endcase
      send_beat(op, v);
    end
    // Drain data is junk on purpose; the core must ignore it.
    for (n = 0; n <= fw; n++) send_beat(OP_DRAIN, TDATA_BITS'($urandom));
  endtask

  // Drops valid, waits for every expected pixel, then lets the pipe go quiet
  // so that the next register write meets an idle core. The first edge lets
  // the last accepted beat reach the predictor before the count is read.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (chk.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random frame sizes, mostly small. Width or height one is sometimes
  // written as zero, which the core must treat the same way.
  task automatic random_phases(input int beat_count);
    int stop_at, fw, fh, frames, f, lead;
    stop_at = beats_sent + beat_count;
    while (beats_sent < stop_at) begin
      fw = ($urandom_range(4) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      fh = $urandom_range(1, 10);
      if (fw == 1 && $urandom_range(1) == 1) fw = 0;
      if (fh == 1 && $urandom_range(1) == 1) fh = 0;
      write_frame_size(fw, fh);
      frames = $urandom_range(1, 3);
      for (f = 0; f < frames; f++) begin
        lead = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0;
        send_frame(PAT_RANDOM, lead, 3);
      end
      settle();
    end
  endtask

  initial begin
    chk = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Regime one: the sender idles now and then, the receiver often.
    tx_idle_pct = 9;
    rx_idle_pct <= 59;

    // Directed frames. A full-scale 3x3 frame sums every channel to its
    // largest value; a checkerboard exercises the floor of the divide; a
    // frame opening with two drain beats stands for surplus drains carried
    // over from the frame before.
    write_frame_size(3, 3);
    send_frame(PAT_FULL, 0, 0);
    send_frame(PAT_CHECKER, 2, 0);
    settle();
    // Width and height written as zero act as one: single-pixel frames,
    // the second of them made of a drain beat only.
    write_frame_size(0, 0);
    send_frame(PAT_RANDOM, 0, 0);
    send_frame(PAT_RANDOM, 1, 0);
    settle();
    random_phases(RANDOM_BEATS);

    // Regime two: the other way round. A wider frame with interior rows.
    tx_idle_pct = 59;
    rx_idle_pct <= 9;
    write_frame_size(64, 4);
    send_frame(PAT_RANDOM, 0, 1);
    settle();
    random_phases(RANDOM_BEATS);

    // Regime three: no idling. A tall frame, one pixel wide.
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    write_frame_size(1, 200);
    send_frame(PAT_RANDOM, 0, 1);
    settle();

    // Back-pressure: the receiver holds off for a long stretch while a full
    // frame is being offered, so the core must drop in_tready and later
    // recover without losing or repeating a beat.
    write_frame_size(10, 8);
    hold_kick <= 1'b1;
    @(posedge clk);
    hold_kick <= 1'b0;
    send_frame(PAT_RANDOM, 0, 3);
    settle();
    random_phases(RANDOM_BEATS);

    if (chk.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
